FILE: rtl/rsr_pkg.sv
package rsr_pkg;

   localparam int SAMPLE_WIDTH   = 24;
   localparam int MAX_WINDOW     = 256;
   localparam int SLOT_WIDTH     = $clog2(MAX_WINDOW);
   localparam int LEN_WIDTH      = 9;
   localparam int SUM_WIDTH      = 32;
   localparam int SQ_WIDTH       = 56;
   localparam int PROD_WIDTH     = 63;
   localparam int DEN_WIDTH      = 71;
   localparam int NUM_WIDTH      = 78;
   localparam int DIVIDEND_WIDTH = NUM_WIDTH + 32;
   localparam int ROOT_WIDTH     = 32;
   localparam int RATIO_WIDTH    = 32;
   localparam int WINDOW_RESET   = 64;
   localparam int WINDOW_MIN     = 2;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] return_sample;
      logic                           start_series;
   } req_type;

   typedef struct packed {
      logic signed [RATIO_WIDTH-1:0] sharpe_ratio;
      logic                          zero_volatility;
      logic                          saturated;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic op_sqrt;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
   } unit_status_type;

endpackage

FILE: rtl/rsr_mul.sv
module rsr_mul
   import rsr_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] product
);

   logic [63:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= a * b;
   end

   assign product = product_ff;

endmodule

FILE: rtl/rsr_divsqrt.sv
module rsr_divsqrt
   import rsr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  unit_ctl_type              ctl,
   input  logic [DIVIDEND_WIDTH-1:0] operand,
   input  logic [DEN_WIDTH-1:0]      divisor,
   output unit_status_type           status,
   output logic [DIVIDEND_WIDTH-1:0] quotient,
   output logic [ROOT_WIDTH-1:0]     root
);

   localparam int REM_WIDTH = DEN_WIDTH + 1;
   localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH);

   logic [DIVIDEND_WIDTH-1:0] work_ff, work_in;
   logic [REM_WIDTH-1:0]      rem_ff, rem_in;
   logic [DEN_WIDTH-1:0]      den_ff;
   logic [ROOT_WIDTH-1:0]     root_ff, root_in;
   logic [CNT_WIDTH-1:0]      count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      op_ff;

   logic [REM_WIDTH-1:0] sub_a, sub_b;
   logic [REM_WIDTH:0]   diff;
   logic                 ge;

   // one shared subtractor serves both the divide and the root step
   always_comb begin
      if (op_ff) begin
         sub_a = {rem_ff[REM_WIDTH-3:0], work_ff[63:62]};
         sub_b = {{(REM_WIDTH-ROOT_WIDTH-2){1'b0}}, root_ff, 2'b01};
      end else begin
         sub_a = {rem_ff[REM_WIDTH-2:0], work_ff[DIVIDEND_WIDTH-1]};
         sub_b = {1'b0, den_ff};
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = ~diff[REM_WIDTH];
   end

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (ctl.start) begin
         work_in  = operand;
         rem_in   = '0;
         root_in  = '0;
         count_in = ctl.op_sqrt ? CNT_WIDTH'(ROOT_WIDTH - 1) : CNT_WIDTH'(DIVIDEND_WIDTH - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[REM_WIDTH-1:0] : sub_a;
         if (op_ff) begin
            root_in = {root_ff[ROOT_WIDTH-2:0], ge};
            work_in = {work_ff[DIVIDEND_WIDTH-3:0], 2'b00};
         end else begin
            work_in = {work_ff[DIVIDEND_WIDTH-2:0], ge};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (ctl.start) begin
         op_ff  <= ctl.op_sqrt;
         den_ff <= divisor;
      end
   end

   assign status.busy = busy_ff;
   assign quotient    = work_ff;
   assign root        = root_ff;

endmodule

FILE: rtl/rolling_sharpe_ratio_core.sv
// Rolling annualized Sharpe ratio core.
// Input channel req_*: one word per return sample (Q3.20) plus a start flag
// that clears the window before the sample is taken. Result channel rsp_*:
// one word per sample once the window holds window_length samples, carrying
// the ratio in Q15.16 (truncated, saturated) and the two status flags.
// Configuration: csr_write_enable/csr_write_data set window_length (clamped
// to 2..256); every write clears the window. Write only while idle.
// A sample that fills the window runs the multiply steps on one shared
// 32x32 multiplier, the bit-serial divider and the bit-serial square root
// (the two share one wide subtractor), then a state that loads the result
// and a return to idle. Zero deviation skips both units; a quotient too
// large for the root skips the root. A sample that does not fill the
// window returns to idle after the sum updates, with no result.
// req_stall is high while a sample is in work. A finished result sits in an
// output register; if rsp_stall holds it, the next sample is still taken and
// its result waits until the register frees.
// Reset clears the window, the write slot, the output valid flag and sets
// window_length to 64. Ring contents are not cleared; an entry that was
// never written may be read but its value is never used.
module rolling_sharpe_ratio_core
   import rsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [LEN_WIDTH-1:0] csr_write_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_OLD  = 4'd1;
   localparam logic [3:0] ST_SQ   = 4'd2;
   localparam logic [3:0] ST_NQ0  = 4'd3;
   localparam logic [3:0] ST_NQ1  = 4'd4;
   localparam logic [3:0] ST_NQ2  = 4'd5;
   localparam logic [3:0] ST_ND0  = 4'd6;
   localparam logic [3:0] ST_ND1  = 4'd7;
   localparam logic [3:0] ST_ND2  = 4'd8;
   localparam logic [3:0] ST_KS1  = 4'd9;
   localparam logic [3:0] ST_KS2  = 4'd10;
   localparam logic [3:0] ST_DIV  = 4'd11;
   localparam logic [3:0] ST_SQRT = 4'd12;
   localparam logic [3:0] ST_FIN  = 4'd13;

   logic [3:0] state_ff, state_in;

   logic [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
   logic [SAMPLE_WIDTH-1:0] old_ff;

   logic [SLOT_WIDTH-1:0]       slot_ff;
   logic [LEN_WIDTH-1:0]        fill_ff, length_ff;
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [SQ_WIDTH-1:0]         sq_ff, sq_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                        drop_ff;
   logic [PROD_WIDTH-1:0]       s2_ff, dd_ff;
   logic [63:0]                 acc_ff;
   logic [DEN_WIDTH-1:0]        den_ff;
   logic                        zero_ff, big_ff;
   rsp_type                     rsp_ff, rsp_in;
   logic                        rsp_valid_ff;

   logic                   accept;
   logic [LEN_WIDTH-1:0]   fill_eff;
   logic [SLOT_WIDTH-1:0]  rd_addr;
   logic [LEN_WIDTH-1:0]   len_clamp;
   logic [15:0]            k_factor;
   logic [7:0]             n_less;
   logic [SAMPLE_WIDTH-1:0] x_mag, old_mag;
   logic [SUM_WIDTH-1:0]   sum_mag;
   logic [31:0]            mul_a, mul_b;
   logic [63:0]            product;
   logic [PROD_WIDTH-1:0]  d0;
   logic [DEN_WIDTH-1:0]   den_sum;
   logic [NUM_WIDTH-1:0]   num_sum;
   logic                   rsp_free;

   unit_ctl_type              unit_ctl;
   unit_status_type           unit_status;
   logic [DIVIDEND_WIDTH-1:0] unit_operand;
   logic [DIVIDEND_WIDTH-1:0] quotient;
   logic [ROOT_WIDTH-1:0]     root;
   logic [ROOT_WIDTH:0]       root_ext;

   function automatic logic [SAMPLE_WIDTH-1:0] mag24(input logic [SAMPLE_WIDTH-1:0] v);
      mag24 = v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign fill_eff  = req_data.start_series ? '0 : fill_ff;
   assign rd_addr   = slot_ff - length_ff[SLOT_WIDTH-1:0];
   assign x_mag     = mag24(req_data.return_sample);
   assign old_mag   = mag24(old_ff);
   assign sum_mag   = sum_ff[SUM_WIDTH-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign n_less    = 8'(length_ff - 1'b1);
   assign k_factor  = {n_less, 8'b0} - {6'b0, n_less, 2'b0};
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (csr_write_data < LEN_WIDTH'(WINDOW_MIN)) begin
         len_clamp = LEN_WIDTH'(WINDOW_MIN);
      end else if (csr_write_data > LEN_WIDTH'(MAX_WINDOW)) begin
         len_clamp = LEN_WIDTH'(MAX_WINDOW);
      end else begin
         len_clamp = csr_write_data;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a = 32'(x_mag);
            mul_b = 32'(x_mag);
         end
         ST_OLD: begin
            mul_a = 32'(old_mag);
            mul_b = 32'(old_mag);
         end
         ST_SQ: begin
            mul_a = sum_mag;
            mul_b = sum_mag;
         end
         ST_NQ0: begin
            mul_a = 32'(length_ff);
            mul_b = sq_ff[31:0];
         end
         ST_NQ1: begin
            mul_a = 32'(length_ff);
            mul_b = 32'(sq_ff[SQ_WIDTH-1:32]);
         end
         ST_ND0: begin
            mul_a = 32'(length_ff);
            mul_b = dd_ff[31:0];
         end
         ST_ND1: begin
            mul_a = 32'(length_ff);
            mul_b = 32'(dd_ff[PROD_WIDTH-1:32]);
         end
         ST_ND2: begin
            mul_a = 32'(k_factor);
            mul_b = s2_ff[31:0];
         end
         ST_KS1: begin
            mul_a = 32'(k_factor);
            mul_b = 32'(s2_ff[PROD_WIDTH-1:32]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   rsr_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (product)
   );

   assign d0      = acc_ff[PROD_WIDTH-1:0] + {product[30:0], 32'b0};
   assign den_sum = {7'b0, acc_ff} + {product[38:0], 32'b0};
   assign num_sum = {14'b0, acc_ff} + {product[45:0], 32'b0};

   always_comb begin
      unit_ctl.start   = 1'b0;
      unit_ctl.op_sqrt = 1'b0;
      unit_operand     = {num_sum, 32'b0};
      if (state_ff == ST_KS2) begin
         unit_ctl.start = 1'b1;
      end else if (state_ff == ST_DIV && !unit_status.busy && quotient[DIVIDEND_WIDTH-1:64] == '0) begin
         unit_ctl.start   = 1'b1;
         unit_ctl.op_sqrt = 1'b1;
         unit_operand     = {{(DIVIDEND_WIDTH-64){1'b0}}, quotient[63:0]};
      end
   end

   rsr_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (unit_ctl),
      .operand  (unit_operand),
      .divisor  (den_ff),
      .status   (unit_status),
      .quotient (quotient),
      .root     (root)
   );

   always_comb begin
      root_ext = big_ff ? {1'b1, {ROOT_WIDTH{1'b0}}} : {1'b0, root};
      rsp_in.zero_volatility = zero_ff;
      rsp_in.saturated       = 1'b0;
      rsp_in.sharpe_ratio    = '0;
      if (!zero_ff) begin
         if (!sum_ff[SUM_WIDTH-1]) begin
            if (root_ext > 33'h0_7FFF_FFFF) begin
               rsp_in.sharpe_ratio = 32'h7FFF_FFFF;
               rsp_in.saturated    = 1'b1;
            end else begin
               rsp_in.sharpe_ratio = root_ext[31:0];
            end
         end else begin
            if (root_ext > 33'h0_8000_0000) begin
               rsp_in.sharpe_ratio = 32'h8000_0000;
               rsp_in.saturated    = 1'b1;
            end else begin
               rsp_in.sharpe_ratio = ~root_ext[31:0] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_OLD;
            end
         end
         ST_OLD: begin
            sum_in = sum_ff + SUM_WIDTH'(x_ff)
                     - (drop_ff ? SUM_WIDTH'($signed(old_ff)) : SUM_WIDTH'(0));
            sq_in  = sq_ff + product[SQ_WIDTH-1:0];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (drop_ff) begin
               sq_in = sq_ff - product[SQ_WIDTH-1:0];
            end
            state_in = (fill_ff >= length_ff) ? ST_NQ0 : ST_IDLE;
         end
         ST_NQ0: state_in = ST_NQ1;
         ST_NQ1: state_in = ST_NQ2;
         ST_NQ2: state_in = (d0 <= s2_ff) ? ST_FIN : ST_ND0;
         ST_ND0: state_in = ST_ND1;
         ST_ND1: state_in = ST_ND2;
         ST_ND2: state_in = ST_KS1;
         ST_KS1: state_in = ST_KS2;
         ST_KS2: state_in = ST_DIV;
         ST_DIV: begin
            if (!unit_status.busy) begin
               state_in = (quotient[DIVIDEND_WIDTH-1:64] != '0) ? ST_FIN : ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!unit_status.busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ring: read the dropped sample before the write lands, also when both use one slot
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff        <= ring[rd_addr];
         ring[slot_ff] <= req_data.return_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         length_ff    <= LEN_WIDTH'(WINDOW_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            length_ff <= len_clamp;
            fill_ff   <= '0;
            sum_ff    <= '0;
            sq_ff     <= '0;
         end else if (accept) begin
            slot_ff <= slot_ff + 1'b1;
            fill_ff <= (fill_eff < length_ff) ? fill_eff + 1'b1 : fill_eff;
            if (req_data.start_series) begin
               sum_ff <= '0;
               sq_ff  <= '0;
            end
         end else begin
            sum_ff <= sum_in;
            sq_ff  <= sq_in;
         end
         if (state_ff == ST_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_data.return_sample;
         drop_ff <= (fill_eff >= length_ff);
      end
      case (state_ff)
         ST_NQ0: s2_ff <= product[PROD_WIDTH-1:0];
         ST_NQ1, ST_ND1, ST_KS1: acc_ff <= product;
         ST_NQ2: begin
            zero_ff <= (d0 <= s2_ff);
            big_ff  <= 1'b0;
            dd_ff   <= d0 - s2_ff;
         end
         ST_ND2: den_ff <= den_sum;
         ST_DIV: big_ff <= (quotient[DIVIDEND_WIDTH-1:64] != '0);
         default: begin
         end
      endcase
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= length_ff)
      else $error("fill count above window length");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      length_ff >= LEN_WIDTH'(WINDOW_MIN) && length_ff <= LEN_WIDTH'(MAX_WINDOW))
      else $error("window length out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("sample accepted while previous one in work");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.zero_volatility && rsp_ff.saturated))
      else $error("zero volatility and saturation both set");

   a_zero_ratio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_volatility |-> rsp_ff.sharpe_ratio == '0)
      else $error("zero volatility with nonzero ratio");

endmodule
